// ===== src/fqm_pkg.sv =====
// Shared package for the FIFO queue with maximum query.
// Holds the operation codes, field widths and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package fqm_pkg;

  localparam int DEFAULT_DEPTH = 64;
  localparam int KEY_W = 32;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_MAX   = 2'd3
  } op_t;

  typedef struct packed {
    logic latch;
    logic load_best;
    logic step;
    logic finish;
    logic sel_ptr;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/fqm_ctrl.sv =====
// Controller state machine for the FIFO queue with maximum query.
// Depends on fqm_pkg for the command and status structs and operation codes.
`default_nettype none

module fqm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire fqm_pkg::stat_t stat,
  output fqm_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.op == fqm_pkg::OP_MAX && !stat.empty) begin
          cmd.sel_ptr = 1'b1;
          cmd.load_best = 1'b1;
          state_next = ST_SCAN;
        end else if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.sel_ptr = 1'b1;
        if (!stat.scan_done) begin
          cmd.step = 1'b1;
        end else if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/fqm_datapath.sv =====
// Datapath for the FIFO queue with maximum query: key memory, ring pointers,
// maximum scan and the output register. Depends on fqm_pkg.
`default_nettype none

module fqm_datapath #(
  parameter int DEPTH = fqm_pkg::DEFAULT_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [1:0]                       operation,
  input  wire logic signed [fqm_pkg::KEY_W-1:0] key_in,
  input  wire fqm_pkg::cmd_t                    cmd,
  output fqm_pkg::stat_t                        stat,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  ok,
  output logic signed [fqm_pkg::KEY_W-1:0]      key_out,
  output logic [fqm_pkg::COUNT_W-1:0]           count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [fqm_pkg::KEY_W-1:0] mem [DEPTH];
  logic signed [fqm_pkg::KEY_W-1:0] rd_data;
  logic signed [fqm_pkg::KEY_W-1:0] key_q;
  logic signed [fqm_pkg::KEY_W-1:0] best;
  fqm_pkg::op_t                     op_q;
  logic [AW-1:0]                    head;
  logic [AW-1:0]                    ptr;
  logic [CW-1:0]                    fill;
  logic [CW-1:0]                    scan_idx;
  logic [AW-1:0]                    rd_addr;
  logic [AW-1:0]                    tail;
  logic [CW:0]                      tail_sum;
  logic                             empty;
  logic                             full;
  logic                             wr_en;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty = (fill == '0);
  assign full = (fill == CW'(DEPTH));
  assign tail_sum = (CW + 1)'(head) + (CW + 1)'(fill);
  assign tail = (tail_sum >= (CW + 1)'(DEPTH)) ? AW'(tail_sum - (CW + 1)'(DEPTH))
                                                : AW'(tail_sum);
  assign rd_addr = cmd.sel_ptr ? ptr : head;
  assign wr_en = cmd.finish && (op_q == fqm_pkg::OP_PUSH) && !full;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= key_q;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    stat.op = op_q;
    stat.empty = empty;
    stat.scan_done = (scan_idx >= fill);
    stat.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q <= fqm_pkg::op_t'(operation);
      key_q <= key_in;
      ptr <= wrap_inc(head);
    end
    if (cmd.load_best) begin
      best <= rd_data;
      scan_idx <= CW'(1);
      ptr <= wrap_inc(ptr);
    end
    if (cmd.step) begin
      if (rd_data > best) begin
        best <= rd_data;
      end
      scan_idx <= scan_idx + 1'b1;
      ptr <= wrap_inc(ptr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        ok <= 1'b0;
        key_out <= '0;
        count <= fqm_pkg::COUNT_W'(fill);
        case (op_q)
          fqm_pkg::OP_PUSH: begin
            if (!full) begin
              fill <= fill + 1'b1;
              ok <= 1'b1;
              count <= fqm_pkg::COUNT_W'(fill + 1'b1);
            end
          end
          fqm_pkg::OP_POP: begin
            if (!empty) begin
              head <= wrap_inc(head);
              fill <= fill - 1'b1;
              ok <= 1'b1;
              key_out <= rd_data;
              count <= fqm_pkg::COUNT_W'(fill - 1'b1);
            end
          end
          fqm_pkg::OP_CLEAR: begin
            head <= '0;
            fill <= '0;
            ok <= 1'b1;
            count <= '0;
          end
          default: begin
            if (!empty) begin
              ok <= 1'b1;
              key_out <= best;
            end
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/fifo_queue_with_max_query.sv =====
// Top level of the FIFO queue with maximum query.
// Instantiates fqm_ctrl and fqm_datapath; depends on fqm_pkg.
//
// Channel | Signals                                  | Direction
// --------+------------------------------------------+----------
// in      | in_valid, in_ready, operation, key_in    | input beat
// out     | out_valid, out_ready, ok, key_out, count | output beat
//
// A push, pop or clear is accepted in idle and executes in run, which waits until out is free.
// A maximum query on a non-empty queue then scans the held keys, one memory read per held key,
// set by the single read port of the key memory.
// rst clears the head pointer, the fill count and the output valid; the key memory is not cleared.
// A new beat is accepted while the previous result waits; the item then holds until out is free.
`default_nettype none

module fifo_queue_with_max_query #(
  parameter int DEPTH = fqm_pkg::DEFAULT_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       operation,
  input  wire logic signed [fqm_pkg::KEY_W-1:0] key_in,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  ok,
  output logic signed [fqm_pkg::KEY_W-1:0]      key_out,
  output logic [fqm_pkg::COUNT_W-1:0]           count
);

  fqm_pkg::cmd_t  cmd;
  fqm_pkg::stat_t stat;

  fqm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fqm_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .operation (operation),
    .key_in    (key_in),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ok        (ok),
    .key_out   (key_out),
    .count     (count)
  );

endmodule

`default_nettype wire
